@@ hdl/pswd_pkg.sv @@
// Shared types, constants, byte-select and CRC helpers for the stored-deflate PNG writer.
package pswd_pkg;

    localparam int          QUEUE_DEPTH = 4;
    localparam int          DIM_W       = 14;
    localparam int          MAX_DIM_DEF = 16383;
    localparam logic [13:0] WIDTH_RST   = 14'd320;
    localparam logic [13:0] HEIGHT_RST  = 14'd240;

    localparam logic        ADDR_WIDTH  = 1'b0;
    localparam logic        ADDR_HEIGHT = 1'b1;

    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD   = 17'd65521;
    localparam logic [63:0] PNG_SIG     = 64'h89504E470D0A1A0A;
    localparam logic [31:0] TAG_IHDR    = 32'h49484452;
    localparam logic [31:0] TAG_IDAT    = 32'h49444154;
    localparam logic [31:0] TAG_IEND    = 32'h49454E44;
    localparam logic [7:0]  ZLIB_CMF    = 8'h78;
    localparam logic [7:0]  ZLIB_FLG    = 8'h01;
    localparam logic [7:0]  IHDR_LEN    = 8'd13;
    localparam logic [7:0]  BIT_DEPTH   = 8'd8;
    localparam logic [7:0]  COLOR_RGBA  = 8'd6;

    localparam logic        FUNC_BEGIN  = 1'b0;

    typedef struct packed {
        logic       is_begin;
        logic       row_start;
        logic       last_row;
        logic       img_end;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_cmd;

    // Big-endian byte select: sel 0 gives the top byte.
    function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] sel);
        logic [7:0] r;
        case (sel)
            2'd0:    r = v[31:24];
            2'd1:    r = v[23:16];
            2'd2:    r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

    // One byte of reflected CRC-32.
    function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'b0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

@@ hdl/pswd_front.sv @@
// Front end: accepts items, tracks row and column, queues commands for the back end.
module pswd_front
    import pswd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [DIM_W-1:0]   i_width,
    input  logic [DIM_W-1:0]   i_height,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [7:0]         i_mem_byte0,
    input  logic [7:0]         i_mem_byte1,
    input  logic [7:0]         i_mem_byte2,
    input  logic [7:0]         i_mem_byte3,
    input  logic               i_q_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic               r_open;
    logic [DIM_W-1:0]   r_col;
    logic [DIM_W-1:0]   r_row;
    logic               n_open;
    logic [DIM_W-1:0]   n_col;
    logic [DIM_W-1:0]   n_row;
    logic               accept;
    logic               is_begin;
    logic               row_end;
    logic               last_row;
    logic [DIM_W:0]     col_inc;
    logic [DIM_W:0]     row_inc;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_begin   = (i_func == FUNC_BEGIN);
    assign col_inc    = {1'b0, r_col} + 1'b1;
    assign row_inc    = {1'b0, r_row} + 1'b1;
    assign row_end    = col_inc >= {1'b0, i_width};
    assign last_row   = row_inc >= {1'b0, i_height};

    // Drop pixels that arrive with no image open.
    assign o_push = accept && (is_begin || r_open);

    always_comb begin
        o_cmd.is_begin  = is_begin;
        o_cmd.row_start = (r_col == '0);
        o_cmd.last_row  = last_row;
        o_cmd.img_end   = row_end && last_row;
        o_cmd.b0        = i_mem_byte0;
        o_cmd.b1        = i_mem_byte1;
        o_cmd.b2        = i_mem_byte2;
        o_cmd.b3        = i_mem_byte3;
    end

    always_comb begin
        n_open = r_open;
        n_col  = r_col;
        n_row  = r_row;
        if (accept) begin
            if (is_begin) begin
                n_open = 1'b1;
                n_col  = '0;
                n_row  = '0;
            end else if (r_open) begin
                if (row_end) begin
                    n_col = '0;
                    if (last_row) begin
                        n_row  = '0;
                        n_open = 1'b0;
                    end else begin
                        n_row = row_inc[DIM_W-1:0];
                    end
                end else begin
                    n_col = col_inc[DIM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_open <= n_open;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

endmodule

@@ hdl/pswd_fifo.sv @@
// Short command queue between the front and back ends.
module pswd_fifo
    import pswd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("push into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pop |-> o_valid)
        else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CW'(DEPTH))
        else $error("queue count overflow");

endmodule

@@ hdl/pswd_back.sv @@
// Back end: running CRC-32/Adler-32 byte sequencer; one byte per cycle if unstalled.
module pswd_back
    import pswd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [DIM_W-1:0]   i_width,
    input  logic [DIM_W-1:0]   i_height,
    input  logic               i_q_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_run_last,
    output logic               o_file_end
);

    typedef enum logic [2:0] {ST_NEW, ST_BEGIN, ST_HDR, ST_PIX, ST_TRL} t_state;

    t_state       r_state;
    logic [5:0]   r_idx;
    logic [31:0]  r_crc;
    logic [15:0]  r_alo;
    logic [15:0]  r_ahi;
    logic [31:0]  r_idat_len;
    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    logic         r_run_last;
    logic         r_file_end;

    t_state       cur;
    t_state       n_state;
    logic [5:0]   n_idx;
    logic         step;
    logic         done;
    logic         fend;
    logic [7:0]   byte_v;
    logic         crc_en;
    logic         crc_restart;
    logic         adl_en;
    logic [31:0]  crc_inv;
    logic [31:0]  crc_in;
    logic [15:0]  blk_len;
    logic [31:0]  w32;
    logic [31:0]  h32;
    logic [16:0]  row_bytes;
    logic [30:0]  prod;
    logic [1:0]   sel29;
    logic [16:0]  lo_sum;
    logic [15:0]  lo_new;
    logic [16:0]  hi_sum;
    logic [15:0]  hi_new;

    assign crc_inv   = ~r_crc;
    assign blk_len   = {i_width, 2'b00} + 16'd1;
    assign w32       = {18'b0, i_width};
    assign h32       = {18'b0, i_height};
    assign row_bytes = {1'b0, i_width, 2'b00} + 17'd6;
    assign prod      = 31'(i_height) * 31'(row_bytes);
    assign sel29     = 2'(r_idx - 6'd29);

    assign cur = (r_state == ST_NEW)
               ? (i_cmd.is_begin ? ST_BEGIN : (i_cmd.row_start ? ST_HDR : ST_PIX))
               : r_state;
    assign step  = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop = step && done;

    always_comb begin
        byte_v      = '0;
        crc_en      = 1'b0;
        crc_restart = 1'b0;
        adl_en      = 1'b0;
        done        = 1'b0;
        fend        = 1'b0;
        unique case (cur)
            ST_BEGIN: begin
                done = (r_idx == 6'd42);
                if (r_idx < 6'd8) begin
                    byte_v = be_byte(r_idx[2] ? PNG_SIG[31:0] : PNG_SIG[63:32], r_idx[1:0]);
                end else if (r_idx < 6'd11) begin
                    byte_v = '0;
                end else if (r_idx == 6'd11) begin
                    byte_v = IHDR_LEN;
                end else if (r_idx < 6'd16) begin
                    byte_v = be_byte(TAG_IHDR, r_idx[1:0]);
                end else if (r_idx < 6'd20) begin
                    byte_v = be_byte(w32, r_idx[1:0]);
                end else if (r_idx < 6'd24) begin
                    byte_v = be_byte(h32, r_idx[1:0]);
                end else if (r_idx == 6'd24) begin
                    byte_v = BIT_DEPTH;
                end else if (r_idx == 6'd25) begin
                    byte_v = COLOR_RGBA;
                end else if (r_idx < 6'd29) begin
                    byte_v = '0;
                end else if (r_idx < 6'd33) begin
                    byte_v = be_byte(crc_inv, sel29);
                end else if (r_idx < 6'd37) begin
                    byte_v = be_byte(r_idat_len, sel29);
                end else if (r_idx < 6'd41) begin
                    byte_v = be_byte(TAG_IDAT, sel29);
                end else if (r_idx == 6'd41) begin
                    byte_v = ZLIB_CMF;
                end else begin
                    byte_v = ZLIB_FLG;
                end
                crc_restart = (r_idx == 6'd12) || (r_idx == 6'd37);
                crc_en      = ((r_idx >= 6'd12) && (r_idx <= 6'd28)) || (r_idx >= 6'd37);
            end
            ST_HDR: begin
                crc_en = 1'b1;
                case (r_idx)
                    6'd0:    byte_v = {7'b0, i_cmd.last_row};
                    6'd1:    byte_v = blk_len[7:0];
                    6'd2:    byte_v = blk_len[15:8];
                    6'd3:    byte_v = ~blk_len[7:0];
                    6'd4:    byte_v = ~blk_len[15:8];
                    default: begin
                        byte_v = '0;
                        adl_en = 1'b1;
                    end
                endcase
            end
            ST_PIX: begin
                crc_en = 1'b1;
                adl_en = 1'b1;
                done   = (r_idx == 6'd3) && !i_cmd.img_end;
                case (r_idx[1:0])
                    2'd0:    byte_v = i_cmd.b2;
                    2'd1:    byte_v = i_cmd.b1;
                    2'd2:    byte_v = i_cmd.b0;
                    default: byte_v = i_cmd.b3;
                endcase
            end
            ST_TRL: begin
                done = (r_idx == 6'd19);
                fend = done;
                if (r_idx < 6'd4) begin
                    byte_v = be_byte({r_ahi, r_alo}, r_idx[1:0]);
                    crc_en = 1'b1;
                end else if (r_idx < 6'd8) begin
                    byte_v = be_byte(crc_inv, r_idx[1:0]);
                end else if (r_idx < 6'd12) begin
                    byte_v = '0;
                end else if (r_idx < 6'd16) begin
                    byte_v      = be_byte(TAG_IEND, r_idx[1:0]);
                    crc_en      = 1'b1;
                    crc_restart = (r_idx == 6'd12);
                end else begin
                    byte_v = be_byte(crc_inv, r_idx[1:0]);
                end
            end
            default: begin
                byte_v = '0;
            end
        endcase
    end

    always_comb begin
        n_state = cur;
        n_idx   = r_idx + 1'b1;
        if (done) begin
            n_state = ST_NEW;
            n_idx   = '0;
        end else if ((cur == ST_HDR) && (r_idx == 6'd5)) begin
            n_state = ST_PIX;
            n_idx   = '0;
        end else if ((cur == ST_PIX) && (r_idx == 6'd3)) begin
            n_state = ST_TRL;
            n_idx   = '0;
        end
    end

    assign crc_in = crc_restart ? 32'hFFFFFFFF : r_crc;

    // Adler-32 with both halves reduced by one compare and subtract.
    assign lo_sum = {1'b0, r_alo} + {9'b0, byte_v};
    assign lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum = {1'b0, r_ahi} + {1'b0, lo_new};
    assign hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

    always_ff @(posedge i_clk) begin
        r_idat_len <= {1'b0, prod} + 32'd6;
        if (step) begin
            r_out_byte <= byte_v;
            r_run_last <= done;
            r_file_end <= fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_NEW;
            r_idx       <= '0;
            r_crc       <= '1;
            r_alo       <= 16'd1;
            r_ahi       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_state     <= n_state;
                r_idx       <= n_idx;
                r_out_valid <= 1'b1;
                if (crc_en) begin
                    r_crc <= crc_byte(crc_in, byte_v);
                end
                if (cur == ST_BEGIN) begin
                    r_alo <= 16'd1;
                    r_ahi <= '0;
                end else if (adl_en) begin
                    r_alo <= lo_new;
                    r_ahi <= hi_new;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_file_end  = r_file_end;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_file_end) |-> r_run_last)
        else $error("file end without run end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TRL) |-> (i_q_valid && i_cmd.img_end))
        else $error("trailer without image end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_NEW) |-> i_q_valid)
        else $error("sequencer busy with empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BEGIN) |-> (r_idx <= 6'd42))
        else $error("header index out of range");

endmodule

@@ hdl/png_stored_deflate_writer.sv @@
// Top level of the stored-deflate PNG stream writer.
// Usage:
// - Input channel (i_in_valid/o_in_ready): i_func=0 begins an image, i_func=1
//   carries one pixel as B,G,R,A bytes in memory order.
// - Output channel (o_out_valid/i_out_ready): one PNG file byte per item,
//   o_run_last on the last byte caused by an input item, o_file_end on the last
//   byte of IEND.
// - APB port: register 0 image width, register 1 image height (14 bits each,
//   0 is taken as 1). Write only while the block is idle.
// Throughput is set by the back-end byte sequencer at one byte per cycle while
// the receiver takes bytes: a pixel gives 4 bytes, 10 at a row start, 20 more
// after the last pixel; a begin item gives 43. An item's first byte is loaded
// into the output register from the head of the 4-deep command queue.
// Pixels with no open image are accepted and dropped.
// Reset closes any image, empties the queue and restores 320 x 240.
// When the receiver stalls, the output register holds; the queue keeps
// accepting items until it is full.
module png_stored_deflate_writer
    import pswd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [7:0]  i_mem_byte0,
    input  logic [7:0]  i_mem_byte1,
    input  logic [7:0]  i_mem_byte2,
    input  logic [7:0]  i_mem_byte3,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_file_end
);

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    t_cmd             push_cmd;
    t_cmd             head_cmd;

    function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign w_eff  = eff_dim(r_width);
    assign h_eff  = eff_dim(r_height);
    assign pready = 1'b1;
    assign prdata = {18'b0, (paddr[2] == ADDR_HEIGHT) ? r_height : r_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                ADDR_WIDTH:  r_width  <= pwdata[DIM_W-1:0];
                ADDR_HEIGHT: r_height <= pwdata[DIM_W-1:0];
                default:     r_width  <= r_width;
            endcase
        end
    end

    pswd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (w_eff),
        .i_height    (h_eff),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_mem_byte0 (i_mem_byte0),
        .i_mem_byte1 (i_mem_byte1),
        .i_mem_byte2 (i_mem_byte2),
        .i_mem_byte3 (i_mem_byte3),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    pswd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    pswd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (w_eff),
        .i_height    (h_eff),
        .i_q_valid   (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_file_end  (o_file_end)
    );

endmodule
